// ===== rtl/core/slc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the sharded LRU cache with admission filter.
// No dependencies.
package slc_pkg;

    localparam int unsigned KEY_W    = 64;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SIZE_W   = 24;
    localparam int unsigned REF_W    = 32;
    localparam int unsigned HITS_W   = 8;
    localparam int unsigned TOK_W    = 8;
    localparam int unsigned AGE_W    = 16;
    localparam int unsigned IDX_W    = 7;
    localparam int unsigned CFG_IW   = 2;
    localparam int unsigned CFG_DW   = 24;
    localparam int unsigned IN_DW    = 184;
    localparam int unsigned OUT_DW   = 56;

    localparam int unsigned DEF_SLOTS  = 8;
    localparam int unsigned DEF_SHARDS = 16;

    localparam logic [AGE_W-1:0]  RST_MAX_AGE   = 16'd60;
    localparam logic [TOK_W-1:0]  RST_IPS       = 8'd16;
    localparam logic [SIZE_W-1:0] RST_MAX_BYTES = 24'd1048576;
    localparam logic [HITS_W-1:0] ADMIT_HITS    = 8'd2;
    localparam logic [HITS_W-1:0] HITS_MAX      = 8'd255;

    typedef enum logic [CFG_IW-1:0] {
        REG_MAX_AGE   = 2'd0,
        REG_IPS       = 2'd1,
        REG_MAX_BYTES = 2'd2
    } t_reg;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERT   = 3'd2,
        ST_THROTTLE = 3'd3,
        ST_NOADMIT  = 3'd4,
        ST_SIZE     = 3'd5
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] mtime;
        logic [TIME_W-1:0] atime;
        logic [REF_W-1:0]  pref;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HITS_W-1:0] hits;
        logic [TIME_W-1:0] atime;
    } t_cand;

    typedef struct packed {
        logic             e_hit;
        logic [IDX_W-1:0] e_hit_idx;
        logic [IDX_W-1:0] e_idx;
        logic             c_match;
        logic [IDX_W-1:0] c_idx;
    } t_pick;

endpackage

// ===== rtl/core/sharded_lru_cache_with_admission_unit.sv =====
`timescale 1ns / 1ps
// Top level of the sharded LRU cache with two-sighting admission filter.
// Depends on slc_pkg, slc_shard and slc_pick.
//
// Requests enter on the s_axis channel: tuser is the request type (0 lookup,
// 1 store), tdata carries key, mtime, size, payload reference and current
// second. Each request gives one result word on m_axis: tuser is the status,
// tdata the found reference and size (zero unless hit).
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data;
// the user must write them only while no request is in flight (the block does not enforce it).
// One request is processed at a time. After acceptance it passes the shard,
// read, evaluate and write states, and the result word is registered at
// write-back; when SHARDS is not a power of two the shard remainder unit
// first works through the key (8 key bits per cycle). The next request is
// accepted in the cycle after the result is registered. Each request reads
// one shard row of the entry and candidate memories, evaluates ages and key
// compares, picks slots and, unless the size check fails, writes the row back.
// Reset clears all valid bits, refills every shard budget to the default
// rate and loads the default register values; no clearing pass is needed.
// A result waits in the output register while m_axis_tready is low; the next
// request is still accepted and held before write-back until it drains.
module sharded_lru_cache_with_admission_unit #(
    parameter int unsigned SLOTS  = slc_pkg::DEF_SLOTS,
    parameter int unsigned SHARDS = slc_pkg::DEF_SHARDS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // key, file_mtime, file_size, payload_ref, now_sec
    input  logic [slc_pkg::IN_DW-1:0]    s_axis_tdata,
    // req_type
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // found_ref, found_size
    output logic [slc_pkg::OUT_DW-1:0]   m_axis_tdata,
    // status
    output logic [2:0]                   m_axis_tuser,
    input  logic                         i_cfg_we,
    input  logic [slc_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [slc_pkg::CFG_DW-1:0]   i_cfg_data
);
    import slc_pkg::*;

    localparam int unsigned CANDS = 2 * SLOTS;
    localparam int unsigned SW    = (SHARDS > 1) ? $clog2(SHARDS) : 1;
    localparam int unsigned EW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW    = $clog2(CANDS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MOD   = 5'b00010,
        S_READ  = 5'b00100,
        S_EVAL  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [AGE_W-1:0]  r_max_age;
    logic [TOK_W-1:0]  r_ips;
    logic [SIZE_W-1:0] r_max_bytes;

    t_entry [SLOTS-1:0] r_emem [SHARDS];
    t_cand  [CANDS-1:0] r_cmem [SHARDS];
    logic [SLOTS-1:0]   r_evalid [SHARDS];
    logic [CANDS-1:0]   r_cvalid [SHARDS];
    logic [TOK_W-1:0]   r_tok [SHARDS];
    logic [TIME_W-1:0]  r_win [SHARDS];

    logic              r_store;
    logic [KEY_W-1:0]  r_key;
    logic [TIME_W-1:0] r_mtime;
    logic [SIZE_W-1:0] r_size;
    logic [REF_W-1:0]  r_ref;
    logic [TIME_W-1:0] r_now;
    logic              r_size_ok;
    logic [SW-1:0]     r_shard;

    t_entry [SLOTS-1:0] r_erow;
    t_cand  [CANDS-1:0] r_crow;
    logic [SLOTS-1:0]   r_evrow;
    logic [CANDS-1:0]   r_cvrow;
    logic [TOK_W-1:0]   r_tokrd;
    logic [TIME_W-1:0]  r_winrd;

    logic [SLOTS-1:0]   r_ev, n_ev, r_ehit, n_ehit;
    logic [CANDS-1:0]   r_cv, n_cv, r_cmatch, n_cmatch;
    logic [TOK_W-1:0]   r_tok_eff, n_tok_eff;

    logic              r_ovalid;
    t_status           r_ostatus;
    logic [REF_W-1:0]  r_oref;
    logic [SIZE_W-1:0] r_osize;

    logic              w_accept, w_free, w_commit;
    logic              w_sh_done;
    logic [SW-1:0]     w_sh;
    logic [SIZE_W-1:0] w_in_size;
    logic [TIME_W-1:0] w_eatime [SLOTS];
    logic [TIME_W-1:0] w_catime [CANDS];
    t_pick             w_pick;

    t_entry [SLOTS-1:0] w_erow;
    t_cand  [CANDS-1:0] w_crow;
    logic [SLOTS-1:0]   w_ev;
    logic [CANDS-1:0]   w_cv;
    logic [TOK_W-1:0]   w_tok;
    t_status            w_status;
    logic [REF_W-1:0]   w_oref;
    logic [SIZE_W-1:0]  w_osize;

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_free    = !r_ovalid || m_axis_tready;
    assign w_commit  = (r_state == S_WRITE) && w_free;
    assign w_in_size = s_axis_tdata[119:96];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ostatus;
    assign m_axis_tdata  = {r_osize, r_oref};

    slc_shard #(.SHARDS(SHARDS)) u_shard (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (s_axis_tdata[63:0]),
        .o_done  (w_sh_done),
        .o_shard (w_sh)
    );

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_eatime[i] = r_erow[i].atime;
        end
        for (int j = 0; j < CANDS; j++) begin
            w_catime[j] = r_crow[j].atime;
        end
    end

    slc_pick #(.SLOTS(SLOTS)) u_pick (
        .i_ev     (r_ev),
        .i_ehit   (r_ehit),
        .i_eatime (w_eatime),
        .i_cv     (r_cv),
        .i_cmatch (r_cmatch),
        .i_catime (w_catime),
        .o_pick   (w_pick)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_MOD;
            S_MOD:   if (w_sh_done) n_state = S_READ;
            S_READ:  n_state = S_EVAL;
            S_EVAL:  n_state = S_WRITE;
            S_WRITE: if (w_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // age, window and key compares on the row just read
    always_comb begin
        logic [TIME_W-1:0] d;
        d = '0;
        if (r_winrd == '0 || r_now != r_winrd) begin
            n_tok_eff = r_ips;
        end else begin
            n_tok_eff = r_tokrd;
        end
        for (int i = 0; i < SLOTS; i++) begin
            d = r_now - r_erow[i].atime;
            n_ev[i] = r_evrow[i] && !(r_now >= r_erow[i].atime &&
                      d > TIME_W'(r_max_age));
            n_ehit[i] = n_ev[i] && (r_erow[i].key == r_key) &&
                        (r_erow[i].mtime == r_mtime);
        end
        for (int j = 0; j < CANDS; j++) begin
            d = r_now - r_crow[j].atime;
            n_cv[j] = r_cvrow[j] && !(r_now >= r_crow[j].atime &&
                      d > TIME_W'(r_max_age));
            n_cmatch[j] = n_cv[j] && (r_crow[j].key == r_key);
        end
    end

    // row update and result
    always_comb begin
        logic [CW-1:0]     ci;
        logic [EW-1:0]     ei;
        logic [EW-1:0]     hi;
        logic [HITS_W-1:0] nh;
        logic              admitted;
        ci       = w_pick.c_idx[CW-1:0];
        ei       = w_pick.e_idx[EW-1:0];
        hi       = w_pick.e_hit_idx[EW-1:0];
        nh       = '0;
        admitted = 1'b0;
        w_erow   = r_erow;
        w_crow   = r_crow;
        w_ev     = r_ev;
        w_cv     = r_cv;
        w_tok    = r_tok_eff;
        w_status = ST_MISS;
        w_oref   = '0;
        w_osize  = '0;
        if (!r_size_ok) begin
            w_status = ST_SIZE;
        end else if (r_store) begin
            if (r_tok_eff == '0) begin
                w_status = ST_THROTTLE;
            end else begin
                if (w_pick.c_match) begin
                    nh = (r_crow[ci].hits == HITS_MAX) ? HITS_MAX
                                                       : r_crow[ci].hits + 1'b1;
                    admitted = (nh >= ADMIT_HITS);
                end else begin
                    nh = HITS_W'(1);
                    w_crow[ci].key = r_key;
                    w_cv[ci] = 1'b1;
                end
                w_crow[ci].hits  = nh;
                w_crow[ci].atime = r_now;
                if (admitted) begin
                    w_erow[ei].key   = r_key;
                    w_erow[ei].mtime = r_mtime;
                    w_erow[ei].atime = r_now;
                    w_erow[ei].pref  = r_ref;
                    w_erow[ei].size  = r_size;
                    w_ev[ei] = 1'b1;
                    w_tok    = r_tok_eff - 1'b1;
                    w_status = ST_INSERT;
                end else begin
                    w_status = ST_NOADMIT;
                end
            end
        end else if (w_pick.e_hit) begin
            w_erow[hi].atime = r_now;
            w_status = ST_HIT;
            w_oref   = r_erow[hi].pref;
            w_osize  = r_erow[hi].size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_max_age   <= RST_MAX_AGE;
            r_ips       <= RST_IPS;
            r_max_bytes <= RST_MAX_BYTES;
            for (int s = 0; s < SHARDS; s++) begin
                r_evalid[s] <= '0;
                r_cvalid[s] <= '0;
                r_tok[s]    <= RST_IPS;
                r_win[s]    <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAX_AGE:   r_max_age   <= i_cfg_data[AGE_W-1:0];
                    REG_IPS:       r_ips       <= i_cfg_data[TOK_W-1:0];
                    REG_MAX_BYTES: r_max_bytes <= i_cfg_data[SIZE_W-1:0];
                    default:       ;
                endcase
            end
            if (w_commit) begin
                r_ovalid <= 1'b1;
                if (r_size_ok) begin
                    r_evalid[r_shard] <= w_ev;
                    r_cvalid[r_shard] <= w_cv;
                    r_tok[r_shard]    <= w_tok;
                    r_win[r_shard]    <= r_now;
                end
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_store   <= s_axis_tuser;
            r_key     <= s_axis_tdata[63:0];
            r_mtime   <= s_axis_tdata[95:64];
            r_size    <= w_in_size;
            r_ref     <= s_axis_tdata[151:120];
            r_now     <= s_axis_tdata[183:152];
            r_size_ok <= (w_in_size != '0) && (w_in_size <= r_max_bytes);
        end
        if (r_state == S_MOD && w_sh_done) begin
            r_shard <= w_sh;
        end
        if (r_state == S_READ) begin
            r_erow  <= r_emem[r_shard];
            r_crow  <= r_cmem[r_shard];
            r_evrow <= r_evalid[r_shard];
            r_cvrow <= r_cvalid[r_shard];
            r_tokrd <= r_tok[r_shard];
            r_winrd <= r_win[r_shard];
        end
        if (r_state == S_EVAL) begin
            r_ev      <= n_ev;
            r_ehit    <= n_ehit;
            r_cv      <= n_cv;
            r_cmatch  <= n_cmatch;
            r_tok_eff <= n_tok_eff;
        end
        if (w_commit) begin
            r_ostatus <= w_status;
            r_oref    <= w_oref;
            r_osize   <= w_osize;
            if (r_size_ok) begin
                r_emem[r_shard] <= w_erow;
                r_cmem[r_shard] <= w_crow;
            end
        end
    end

endmodule

// ===== rtl/core/slc_shard.sv =====
`timescale 1ns / 1ps
// Shard selector: key modulo SHARDS, eight key bits per cycle by restoring
// subtraction, or a plain bit slice when SHARDS is a power of two. Uses slc_pkg.
module slc_shard #(
    parameter int unsigned SHARDS = slc_pkg::DEF_SHARDS
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_start,
    input  logic [slc_pkg::KEY_W-1:0]                      i_key,
    output logic                                           o_done,
    output logic [((SHARDS > 1) ? $clog2(SHARDS) : 1)-1:0] o_shard
);
    import slc_pkg::*;

    localparam int unsigned SW    = (SHARDS > 1) ? $clog2(SHARDS) : 1;
    localparam bit          POW2  = (SHARDS > 1) && ((1 << SW) == SHARDS);
    localparam int unsigned STEPS = KEY_W / 8;
    localparam int unsigned CNT_W = $clog2(STEPS + 1);
    localparam logic [SW:0] SH_C  = (SW + 1)'(SHARDS);

    logic [KEY_W-1:0] r_key;
    logic [SW-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [SW:0]      w_tmp;

    always_comb begin
        n_rem = r_rem;
        w_tmp = '0;
        for (int b = 0; b < 8; b++) begin
            w_tmp = {n_rem, r_key[KEY_W-1-b]};
            if (w_tmp >= SH_C) begin
                w_tmp = w_tmp - SH_C;
            end
            n_rem = w_tmp[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
            r_rem <= '0;
        end else if (r_busy && !POW2) begin
            r_key <= {r_key[KEY_W-9:0], 8'd0};
            r_rem <= n_rem;
        end
    end

    assign o_done  = r_busy && (POW2 || (r_cnt == CNT_W'(STEPS)));
    assign o_shard = POW2 ? r_key[SW-1:0] : r_rem;

endmodule

// ===== rtl/core/slc_pick.sv =====
`timescale 1ns / 1ps
// Slot selection for one shard row: lowest hit, first free or least recently
// used entry, and the lowest candidate that matches or is free, else the oldest. Uses slc_pkg.
module slc_pick #(
    parameter int unsigned SLOTS = slc_pkg::DEF_SLOTS
) (
    input  logic [SLOTS-1:0]                     i_ev,
    input  logic [SLOTS-1:0]                     i_ehit,
    input  logic [slc_pkg::TIME_W-1:0]           i_eatime [SLOTS],
    input  logic [2*SLOTS-1:0]                   i_cv,
    input  logic [2*SLOTS-1:0]                   i_cmatch,
    input  logic [slc_pkg::TIME_W-1:0]           i_catime [2*SLOTS],
    output slc_pkg::t_pick                       o_pick
);
    import slc_pkg::*;

    localparam int unsigned CANDS = 2 * SLOTS;
    localparam int unsigned EL    = $clog2(SLOTS);
    localparam int unsigned EP    = 1 << EL;
    localparam int unsigned CL    = $clog2(CANDS);
    localparam int unsigned CP    = 1 << CL;

    logic [TIME_W-1:0] w_ev_t [EL+1][EP];
    logic [IDX_W-1:0]  w_ei_t [EL+1][EP];
    logic              w_eo_t [EL+1][EP];
    logic [TIME_W-1:0] w_cv_t [CL+1][CP];
    logic [IDX_W-1:0]  w_ci_t [CL+1][CP];
    logic              w_co_t [CL+1][CP];

    always_comb begin
        for (int l = 0; l <= EL; l++) begin
            for (int k = 0; k < EP; k++) begin
                w_ev_t[l][k] = '0;
                w_ei_t[l][k] = '0;
                w_eo_t[l][k] = 1'b0;
            end
        end
        for (int k = 0; k < SLOTS; k++) begin
            w_ev_t[0][k] = i_eatime[k];
            w_ei_t[0][k] = IDX_W'(k);
            w_eo_t[0][k] = 1'b1;
        end
        for (int l = 0; l < EL; l++) begin
            for (int k = 0; k < (EP >> (l + 1)); k++) begin
                if (w_eo_t[l][2*k+1] && (!w_eo_t[l][2*k] ||
                        w_ev_t[l][2*k+1] < w_ev_t[l][2*k])) begin
                    w_ev_t[l+1][k] = w_ev_t[l][2*k+1];
                    w_ei_t[l+1][k] = w_ei_t[l][2*k+1];
                end else begin
                    w_ev_t[l+1][k] = w_ev_t[l][2*k];
                    w_ei_t[l+1][k] = w_ei_t[l][2*k];
                end
                w_eo_t[l+1][k] = w_eo_t[l][2*k] | w_eo_t[l][2*k+1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l <= CL; l++) begin
            for (int k = 0; k < CP; k++) begin
                w_cv_t[l][k] = '0;
                w_ci_t[l][k] = '0;
                w_co_t[l][k] = 1'b0;
            end
        end
        for (int k = 0; k < CANDS; k++) begin
            w_cv_t[0][k] = i_catime[k];
            w_ci_t[0][k] = IDX_W'(k);
            w_co_t[0][k] = 1'b1;
        end
        for (int l = 0; l < CL; l++) begin
            for (int k = 0; k < (CP >> (l + 1)); k++) begin
                if (w_co_t[l][2*k+1] && (!w_co_t[l][2*k] ||
                        w_cv_t[l][2*k+1] < w_cv_t[l][2*k])) begin
                    w_cv_t[l+1][k] = w_cv_t[l][2*k+1];
                    w_ci_t[l+1][k] = w_ci_t[l][2*k+1];
                end else begin
                    w_cv_t[l+1][k] = w_cv_t[l][2*k];
                    w_ci_t[l+1][k] = w_ci_t[l][2*k];
                end
                w_co_t[l+1][k] = w_co_t[l][2*k] | w_co_t[l][2*k+1];
            end
        end
    end

    always_comb begin
        logic e_found;
        logic c_found;
        o_pick   = '0;
        e_found  = 1'b0;
        c_found  = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (i_ehit[i]) begin
                o_pick.e_hit     = 1'b1;
                o_pick.e_hit_idx = IDX_W'(i);
            end
        end
        o_pick.e_idx = w_ei_t[EL][0];
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!i_ev[i]) begin
                e_found      = 1'b1;
                o_pick.e_idx = IDX_W'(i);
            end
        end
        o_pick.c_idx = w_ci_t[CL][0];
        for (int j = CANDS - 1; j >= 0; j--) begin
            if (!i_cv[j] || i_cmatch[j]) begin
                c_found        = 1'b1;
                o_pick.c_idx   = IDX_W'(j);
                o_pick.c_match = i_cmatch[j];
            end
        end
        if (!c_found) begin
            o_pick.c_match = 1'b0;
        end
        if (!e_found) begin
            o_pick.e_idx = w_ei_t[EL][0];
        end
    end

endmodule

// ===== rtl/core/slc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the sharded LRU cache top level, bound to it below.
// Uses slc_pkg.
module slc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [slc_pkg::OUT_DW-1:0] m_axis_tdata,
    input logic [2:0]                 m_axis_tuser
);
    import slc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word accepted while one is in work");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_HIT |-> m_axis_tdata == '0)
        else $error("nonzero data on a result that is not a hit");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= ST_SIZE)
        else $error("status code out of range");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 !s_axis_tready)
        else $error("request finished too early");

endmodule

bind sharded_lru_cache_with_admission_unit slc_checker u_slc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
